// ===== rtl/core/ffha_pkg.sv =====
// Shared types and codes of the first-fit heap allocator.
// Depends on nothing; imported by the allocator top level.
`default_nettype none
package ffha_pkg;
	localparam logic [2:0] OP_ALLOC_LOW  = 3'd0;
	localparam logic [2:0] OP_ALLOC_HIGH = 3'd1;
	localparam logic [2:0] OP_FREE       = 3'd2;
	localparam logic [2:0] OP_RESIZE     = 3'd3;
	localparam logic [2:0] OP_REPORT     = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_FIT      = 3'd1;
	localparam logic [2:0] ST_BAD_ADDR    = 3'd2;
	localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
	localparam logic [2:0] ST_NO_ROOM     = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd5;

	localparam logic       REG_HEAP_BASE  = 1'b0;
	localparam logic       REG_HEAP_BYTES = 1'b1;

	localparam logic [24:0] HEAP_LIMIT = 25'h1000000;
	localparam logic [15:0] FAIL_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [23:0] blk_off;
		logic [24:0] blk_pay;
		logic        blk_free;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOW_RD, S_LOW_CHK, S_HIGH_RD, S_HIGH_CHK, S_ALLOC,
		S_INS_RD, S_INS_WR, S_FIND_RD, S_FIND_CHK, S_NBP_RD, S_NBP_CHK,
		S_NBN_RD, S_NBN_CHK, S_DECIDE, S_WR2, S_REL, S_RM_RD, S_RM_WR,
		S_RP_RD, S_RP_CHK, S_FIN
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: sequencer, block table RAM, registers.
// Depends on ffha_pkg and ffha_ram.
//
//  channel  | handshake                  | payload
//  request  | start, busy                | operation, request_bytes, payload_address
//  result   | done (one-cycle strobe)    | result_address, status, total_free,
//           |                            | total_allocated, largest_free, failure_count
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One request at a time; busy drops in the cycle done rises. Each table entry visited
// takes an address state and a check state on the single RAM read port (address, then
// registered data), and each entry shifted by an insert or remove takes a read state
// and a write state; a free of address 0 or an unknown operation goes straight from idle
// to S_FIN, which raises done, and a moving resize, which may insert and remove, is longest.
// Reset (arst_n low) sets one free block over the default heap with no RAM sweep.
// The receiver cannot stall: done is a one-cycle strobe. cfg_ready is low while start is high.
`default_nettype none
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [24:0] request_bytes,
	input  wire logic [31:0] payload_address,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [31:0]      result_address,
	output logic [2:0]       status,
	output logic [24:0]      total_free,
	output logic [24:0]      total_allocated,
	output logic [24:0]      largest_free,
	output logic [15:0]      failure_count
);
	import ffha_pkg::*;

	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int CW1 = CW + 1;
	localparam int EW  = $bits(entry_t);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [26:0]   HDR  = 27'(HEADER_BYTES);
	localparam logic [31:0]   HDR32 = 32'(HEADER_BYTES);

	state_t state_q, state_d;
	logic [25:0] size_q, size_d;
	logic [31:0] addr_q, addr_d, rel_q, rel_d;
	logic [CW-1:0] ptr_q, ptr_d, cnt_q, cnt_d;
	logic [IW-1:0] idx_q, idx_d, ins_pos_q, ins_pos_d, pend_idx_q, pend_idx_d;
	entry_t cur_q, cur_d, prv_q, prv_d, nxt_q, nxt_d, ins_q, ins_d, pend_q, pend_d;
	logic pf_q, pf_d, nf_q, nf_d, hi_q, hi_d, mv_q, mv_d, rz_q, rz_d, cf_q, cf_d;
	logic two_q, two_d, init0_q, init0_d, ovr_q, ovr_d, done_q, done_d;
	logic [2:0]  st_q, st_d;
	logic [31:0] res_q, res_d;
	logic [24:0] acc_q, acc_d, tf_q, tf_d, ta_q, ta_d, lf_q, lf_d;
	logic [15:0] fail_q, fail_d;
	logic [31:0] base_q, base_d;
	logic [24:0] hbytes_q, hbytes_d;
	logic [31:0] ores_q, ores_d;
	logic [2:0]  ost_q, ost_d;
	logic [24:0] otf_q, otf_d, ota_q, ota_d, olf_q, olf_d;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata;
	logic [EW-1:0] ram_rdata;
	entry_t        rd_e, rebuild_e;
	logic [24:0]   len;
	logic [31:0]   base_al;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign len       = {hbytes_q[24:4], 4'b0};
	assign rebuild_e = '{blk_off: 24'd0, blk_pay: 25'({2'b0, len} - HDR), blk_free: 1'b1};
	assign rd_e      = ovr_q ? rebuild_e : entry_t'(ram_rdata);
	assign base_al   = {base_q[31:4], 4'b0};
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign done            = done_q;
	assign result_address  = ores_q;
	assign status          = ost_q;
	assign total_free      = otf_q;
	assign total_allocated = ota_q;
	assign largest_free    = olf_q;
	assign failure_count   = fail_q;

	function automatic logic [31:0] pay_addr(input logic [31:0] b, input logic [23:0] o);
		pay_addr = b + 32'(o) + HDR32;
	endfunction

	always_comb begin
		logic [26:0]  s27, c27, n27, o27, sz_h;
		logic [25:0]  diff, size_in;
		logic [24:0]  s25, hb_new, len_new;
		logic [CW1-1:0] pd;
		logic          split;
		s27  = 27'(size_q);
		c27  = {2'b0, cur_q.blk_pay};
		n27  = {2'b0, nxt_q.blk_pay};
		o27  = {3'b0, cur_q.blk_off};
		sz_h = s27 + HDR;
		s25  = size_q[24:0];
		diff = size_q - {1'b0, cur_q.blk_pay};
		split = sz_h < c27;
		size_in = ({1'b0, request_bytes} + 26'd15) & ~26'hF;
		hb_new  = (cfg_data[24:0] > HEAP_LIMIT) ? HEAP_LIMIT : cfg_data[24:0];
		len_new = {hb_new[24:4], 4'b0};
		pd = {1'b0, ptr_q} + (two_q ? CW1'(2) : CW1'(1));

		state_d = state_q; size_d = size_q; addr_d = addr_q; rel_d = rel_q;
		ptr_d = ptr_q; cnt_d = cnt_q; idx_d = idx_q; ins_pos_d = ins_pos_q;
		pend_idx_d = pend_idx_q; cur_d = cur_q; prv_d = prv_q; nxt_d = nxt_q;
		ins_d = ins_q; pend_d = pend_q; pf_d = pf_q; nf_d = nf_q; hi_d = hi_q;
		mv_d = mv_q; rz_d = rz_q; cf_d = cf_q; two_d = two_q; init0_d = init0_q;
		st_d = st_q; res_d = res_q; acc_d = acc_q; tf_d = tf_q; ta_d = ta_q; lf_d = lf_q;
		fail_d = fail_q; base_d = base_q; hbytes_d = hbytes_q; done_d = 1'b0;
		ores_d = ores_q; ost_d = ost_q; otf_d = otf_q; ota_d = ota_q; olf_d = olf_q;
		ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					size_d = size_in; addr_d = payload_address;
					rel_d = payload_address - base_al - HDR32;
					ptr_d = '0; st_d = ST_OK; res_d = '0; tf_d = '0; ta_d = '0; lf_d = '0;
					mv_d = 1'b0; rz_d = 1'b0; cf_d = 1'b0;
					unique case (operation)
						OP_ALLOC_LOW: begin
							cf_d = 1'b1; state_d = S_LOW_RD;
						end
						OP_ALLOC_HIGH: begin
							cf_d = 1'b1; ptr_d = cnt_q; state_d = S_HIGH_RD;
						end
						OP_FREE: begin
							state_d = (payload_address == '0) ? S_FIN : S_FIND_RD;
						end
						OP_RESIZE: begin
							if (payload_address == '0) begin
								cf_d = 1'b1; state_d = S_LOW_RD;
							end else if (size_in == '0) begin
								state_d = S_FIND_RD;
							end else begin
								cf_d = 1'b1; rz_d = 1'b1; state_d = S_FIND_RD;
							end
						end
						OP_REPORT: state_d = S_RP_RD;
						default: state_d = S_FIN;
					endcase
				end
				if (cfg_valid && cfg_ready) begin
					if (cfg_index == REG_HEAP_BASE) begin
						base_d = cfg_data;
					end else begin
						hbytes_d = hb_new;
						init0_d  = 1'b1;
						cnt_d    = ({2'b0, len_new} > HDR) ? CW'(1) : '0;
					end
				end
			end
			S_LOW_RD: begin
				if (ptr_q >= cnt_q) begin
					st_d = ST_NO_FIT; state_d = S_FIN;
				end else begin
					ram_raddr = IW'(ptr_q); state_d = S_LOW_CHK;
				end
			end
			S_LOW_CHK: begin
				if (rd_e.blk_free && {1'b0, rd_e.blk_pay} >= size_q) begin
					cur_d = rd_e; idx_d = IW'(ptr_q); hi_d = 1'b0; state_d = S_ALLOC;
				end else begin
					ptr_d = ptr_q + CW'(1); state_d = S_LOW_RD;
				end
			end
			S_HIGH_RD: begin
				if (ptr_q == '0) begin
					st_d = ST_NO_FIT; state_d = S_FIN;
				end else begin
					ram_raddr = IW'(ptr_q - CW'(1)); state_d = S_HIGH_CHK;
				end
			end
			S_HIGH_CHK: begin
				if (rd_e.blk_free && {1'b0, rd_e.blk_pay} >= size_q) begin
					cur_d = rd_e; idx_d = IW'(ptr_q - CW'(1)); hi_d = 1'b1; state_d = S_ALLOC;
				end else begin
					ptr_d = ptr_q - CW'(1); state_d = S_HIGH_RD;
				end
			end
			S_ALLOC: begin
				if (!split) begin
					ram_we = 1'b1; ram_waddr = idx_q;
					ram_wdata = '{blk_off: cur_q.blk_off, blk_pay: cur_q.blk_pay, blk_free: 1'b0};
					res_d = pay_addr(base_al, cur_q.blk_off);
					ptr_d = '0; rz_d = 1'b0;
					state_d = mv_q ? S_FIND_RD : S_FIN;
				end else if (cnt_q == MAXC) begin
					st_d = ST_TABLE_FULL; state_d = S_FIN;
				end else begin
					ram_we = 1'b1; ram_waddr = idx_q;
					if (!hi_q) begin
						ram_wdata = '{blk_off: cur_q.blk_off, blk_pay: s25, blk_free: 1'b0};
						ins_d = '{blk_off: 24'(o27 + sz_h), blk_pay: 25'(c27 - sz_h),
							blk_free: 1'b1};
						res_d = pay_addr(base_al, cur_q.blk_off);
					end else begin
						ram_wdata = '{blk_off: cur_q.blk_off, blk_pay: 25'(c27 - sz_h),
							blk_free: 1'b1};
						ins_d = '{blk_off: 24'(o27 + c27 - s27), blk_pay: s25, blk_free: 1'b0};
						res_d = pay_addr(base_al, 24'(o27 + c27 - s27));
					end
					ins_pos_d = idx_q + IW'(1); ptr_d = cnt_q; state_d = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (ptr_q == CW'(ins_pos_q)) begin
					ram_we = 1'b1; ram_waddr = ins_pos_q; ram_wdata = ins_q;
					cnt_d = cnt_q + CW'(1); ptr_d = '0; rz_d = 1'b0;
					state_d = mv_q ? S_FIND_RD : S_FIN;
				end else begin
					ram_raddr = IW'(ptr_q - CW'(1)); state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				ram_we = 1'b1; ram_waddr = IW'(ptr_q); ram_wdata = rd_e;
				ptr_d = ptr_q - CW'(1); state_d = S_INS_RD;
			end
			S_FIND_RD: begin
				if (ptr_q >= cnt_q) begin
					st_d = mv_q ? ST_OK : ST_BAD_ADDR; state_d = S_FIN;
				end else begin
					ram_raddr = IW'(ptr_q); state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if ({8'b0, rd_e.blk_off} == rel_q) begin
					cur_d = rd_e; idx_d = IW'(ptr_q); state_d = S_NBP_RD;
				end else begin
					ptr_d = ptr_q + CW'(1); state_d = S_FIND_RD;
				end
			end
			S_NBP_RD: begin
				pf_d = 1'b0;
				if (idx_q != '0) begin
					ram_raddr = idx_q - IW'(1); state_d = S_NBP_CHK;
				end else begin
					state_d = S_NBN_RD;
				end
			end
			S_NBP_CHK: begin
				prv_d = rd_e; pf_d = rd_e.blk_free; state_d = S_NBN_RD;
			end
			S_NBN_RD: begin
				nf_d = 1'b0;
				if (CW'(idx_q) + CW'(1) < cnt_q) begin
					ram_raddr = idx_q + IW'(1); state_d = S_NBN_CHK;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_NBN_CHK: begin
				nxt_d = rd_e; nf_d = rd_e.blk_free; state_d = S_DECIDE;
			end
			S_DECIDE: begin
				pend_d = '{blk_off: cur_q.blk_off, blk_pay: s25, blk_free: 1'b0};
				pend_idx_d = idx_q;
				if (!rz_q) begin
					if (cur_q.blk_free) begin
						st_d = ST_DOUBLE_FREE; state_d = S_FIN;
					end else begin
						acc_d = 25'(c27 + (nf_q ? (n27 + HDR) : 27'd0));
						state_d = S_REL;
					end
				end else if (cur_q.blk_free) begin
					st_d = ST_BAD_ADDR; state_d = S_FIN;
				end else if (size_q == {1'b0, cur_q.blk_pay}) begin
					res_d = addr_q; state_d = S_FIN;
				end else if (size_q > {1'b0, cur_q.blk_pay}) begin
					if (nf_q && {1'b0, nxt_q.blk_pay} >= diff) begin
						ram_we = 1'b1; ram_waddr = idx_q + IW'(1);
						ram_wdata = '{blk_off: 24'({3'b0, nxt_q.blk_off} + 27'(diff)),
							blk_pay: 25'(n27 - 27'(diff)), blk_free: 1'b1};
						res_d = addr_q; state_d = S_WR2;
					end else begin
						mv_d = 1'b1; ptr_d = '0; state_d = S_LOW_RD;
					end
				end else if (nf_q) begin
					ram_we = 1'b1; ram_waddr = idx_q + IW'(1);
					ram_wdata = '{blk_off: 24'(o27 + sz_h), blk_pay: 25'(n27 + c27 - s27),
						blk_free: 1'b1};
					res_d = addr_q; state_d = S_WR2;
				end else if (split) begin
					if (cnt_q == MAXC) begin
						st_d = ST_TABLE_FULL; state_d = S_FIN;
					end else begin
						ram_we = 1'b1; ram_waddr = idx_q;
						ram_wdata = '{blk_off: cur_q.blk_off, blk_pay: s25, blk_free: 1'b0};
						ins_d = '{blk_off: 24'(o27 + sz_h), blk_pay: 25'(c27 - sz_h),
							blk_free: 1'b1};
						ins_pos_d = idx_q + IW'(1); ptr_d = cnt_q;
						res_d = addr_q; state_d = S_INS_RD;
					end
				end else begin
					st_d = ST_NO_ROOM; state_d = S_FIN;
				end
			end
			S_WR2: begin
				ram_we = 1'b1; ram_waddr = pend_idx_q; ram_wdata = pend_q;
				state_d = S_FIN;
			end
			S_REL: begin
				ram_we = 1'b1;
				if (pf_q) begin
					ram_waddr = idx_q - IW'(1);
					ram_wdata = '{blk_off: prv_q.blk_off,
						blk_pay: 25'({2'b0, prv_q.blk_pay} + {2'b0, acc_q} + HDR), blk_free: 1'b1};
					ptr_d = CW'(idx_q); two_d = nf_q; state_d = S_RM_RD;
				end else begin
					ram_waddr = idx_q;
					ram_wdata = '{blk_off: cur_q.blk_off, blk_pay: acc_q, blk_free: 1'b1};
					ptr_d = CW'(idx_q) + CW'(1); two_d = 1'b0;
					state_d = nf_q ? S_RM_RD : S_FIN;
				end
			end
			S_RM_RD: begin
				if (pd >= {1'b0, cnt_q}) begin
					cnt_d = cnt_q - (two_q ? CW'(2) : CW'(1)); state_d = S_FIN;
				end else begin
					ram_raddr = IW'(pd); state_d = S_RM_WR;
				end
			end
			S_RM_WR: begin
				ram_we = 1'b1; ram_waddr = IW'(ptr_q); ram_wdata = rd_e;
				ptr_d = ptr_q + CW'(1); state_d = S_RM_RD;
			end
			S_RP_RD: begin
				if (ptr_q >= cnt_q) begin
					state_d = S_FIN;
				end else begin
					ram_raddr = IW'(ptr_q); state_d = S_RP_CHK;
				end
			end
			S_RP_CHK: begin
				if (rd_e.blk_free) begin
					tf_d = tf_q + rd_e.blk_pay;
					if (rd_e.blk_pay > lf_q) begin
						lf_d = rd_e.blk_pay;
					end
				end else begin
					ta_d = ta_q + rd_e.blk_pay;
				end
				ptr_d = ptr_q + CW'(1); state_d = S_RP_RD;
			end
			S_FIN: begin
				done_d = 1'b1;
				if (st_q != ST_OK && cf_q && fail_q != FAIL_MAX) begin
					fail_d = fail_q + 16'd1;
				end
				ores_d = (st_q == ST_OK) ? res_q : '0;
				ost_d = st_q; otf_d = tf_q; ota_d = ta_q; olf_d = lf_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		if (ram_we && ram_waddr == '0) begin
			init0_d = 1'b0;
		end
		ovr_d = init0_q && (ram_raddr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1); init0_q <= 1'b1; ovr_q <= 1'b0; done_q <= 1'b0;
			fail_q <= '0; base_q <= '0; hbytes_q <= 25'd65536;
			mv_q <= 1'b0; rz_q <= 1'b0; cf_q <= 1'b0; hi_q <= 1'b0; two_q <= 1'b0;
			pf_q <= 1'b0; nf_q <= 1'b0; ptr_q <= '0; st_q <= ST_OK;
		end else begin
			cnt_q <= cnt_d; init0_q <= init0_d; ovr_q <= ovr_d; done_q <= done_d;
			fail_q <= fail_d; base_q <= base_d; hbytes_q <= hbytes_d;
			mv_q <= mv_d; rz_q <= rz_d; cf_q <= cf_d; hi_q <= hi_d; two_q <= two_d;
			pf_q <= pf_d; nf_q <= nf_d; ptr_q <= ptr_d; st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		size_q <= size_d; addr_q <= addr_d; rel_q <= rel_d;
		idx_q <= idx_d; ins_pos_q <= ins_pos_d; pend_idx_q <= pend_idx_d;
		cur_q <= cur_d; prv_q <= prv_d; nxt_q <= nxt_d; ins_q <= ins_d; pend_q <= pend_d;
		res_q <= res_d; acc_q <= acc_d; tf_q <= tf_d; ta_q <= ta_d; lf_q <= lf_d;
		ores_q <= ores_d; ost_q <= ost_d; otf_q <= otf_d; ota_q <= ota_d; olf_q <= olf_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/ffha_checker.sv =====
`timescale 1ns / 1ps
// Checker for the first-fit heap allocator: mirrors the block table, predicts each
// response from accepted requests and register writes, and compares it. Uses ffha_pkg.
module ffha_checker #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [24:0] request_bytes,
	input  logic [31:0] payload_address,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic [31:0] result_address,
	input  logic [2:0]  status,
	input  logic [24:0] total_free,
	input  logic [24:0] total_allocated,
	input  logic [24:0] largest_free,
	input  logic [15:0] failure_count,
	output int          errors
);
	import ffha_pkg::*;

	localparam logic [31:0] HDR = HEADER_BYTES;

	typedef struct {
		logic [31:0] addr;
		logic [2:0]  st;
		logic [24:0] tf;
		logic [24:0] ta;
		logic [24:0] lf;
		logic [15:0] fc;
	} answer_t;

	logic [31:0] heap_base_q;
	logic [31:0] heap_len_q;
	logic [31:0] blk_off [MAX_BLOCKS];
	logic [31:0] blk_pay [MAX_BLOCKS];
	logic        blk_fr  [MAX_BLOCKS];
	int          blk_n;
	logic [15:0] fails;
	answer_t     answers_q[$];

	function automatic void rebuild_heap();
		logic [31:0] len;
		len = heap_len_q & 32'hFFFF_FFF0;
		for (int j = 0; j < MAX_BLOCKS; j++) begin
			blk_off[j] = '0;
			blk_pay[j] = '0;
			blk_fr[j]  = 1'b0;
		end
		if (len > HDR) begin
			blk_pay[0] = len - HDR;
			blk_fr[0]  = 1'b1;
			blk_n      = 1;
		end else begin
			blk_n = 0;
		end
	endfunction

	function automatic logic [31:0] payload_of(int i);
		return (heap_base_q & 32'hFFFF_FFF0) + blk_off[i] + HDR;
	endfunction

	function automatic void entry_insert(int pos, logic [31:0] off, logic [31:0] pay,
			logic fr);
		for (int j = blk_n; j > pos; j--) begin
			blk_off[j] = blk_off[j-1];
			blk_pay[j] = blk_pay[j-1];
			blk_fr[j]  = blk_fr[j-1];
		end
		blk_off[pos] = off;
		blk_pay[pos] = pay;
		blk_fr[pos]  = fr;
		blk_n++;
	endfunction

	function automatic void entry_remove(int pos);
		for (int j = pos; j + 1 < blk_n; j++) begin
			blk_off[j] = blk_off[j+1];
			blk_pay[j] = blk_pay[j+1];
			blk_fr[j]  = blk_fr[j+1];
		end
		blk_n--;
		blk_off[blk_n] = '0;
		blk_pay[blk_n] = '0;
		blk_fr[blk_n]  = 1'b0;
	endfunction

	function automatic int entry_find(logic [31:0] addr);
		logic [31:0] rel;
		rel = addr - (heap_base_q & 32'hFFFF_FFF0) - HDR;
		for (int i = 0; i < blk_n; i++)
			if (blk_off[i] == rel)
				return i;
		return -1;
	endfunction

	function automatic logic [2:0] claim_low(logic [31:0] sz, output logic [31:0] addr);
		addr = '0;
		for (int i = 0; i < blk_n; i++) begin
			if (blk_fr[i] && blk_pay[i] >= sz) begin
				if (sz + HDR < blk_pay[i]) begin
					if (blk_n >= MAX_BLOCKS)
						return ST_TABLE_FULL;
					entry_insert(i + 1, blk_off[i] + sz + HDR, blk_pay[i] - sz - HDR, 1'b1);
					blk_pay[i] = sz;
				end
				blk_fr[i] = 1'b0;
				addr = payload_of(i);
				return ST_OK;
			end
		end
		return ST_NO_FIT;
	endfunction

	function automatic logic [2:0] claim_high(logic [31:0] sz, output logic [31:0] addr);
		int k;
		logic [31:0] off;
		addr = '0;
		for (int i = blk_n; i > 0; i--) begin
			k = i - 1;
			if (blk_fr[k] && blk_pay[k] >= sz) begin
				if (sz + HDR < blk_pay[k]) begin
					if (blk_n >= MAX_BLOCKS)
						return ST_TABLE_FULL;
					off = blk_off[k] + blk_pay[k] - sz;
					blk_pay[k] = blk_pay[k] - sz - HDR;
					entry_insert(k + 1, off, sz, 1'b0);
					k++;
				end
				blk_fr[k] = 1'b0;
				addr = payload_of(k);
				return ST_OK;
			end
		end
		return ST_NO_FIT;
	endfunction

	function automatic void merge_free(int idx);
		blk_fr[idx] = 1'b1;
		if (idx + 1 < blk_n && blk_fr[idx+1]) begin
			blk_pay[idx] = blk_pay[idx] + blk_pay[idx+1] + HDR;
			entry_remove(idx + 1);
		end
		if (idx > 0 && blk_fr[idx-1]) begin
			blk_pay[idx-1] = blk_pay[idx-1] + blk_pay[idx] + HDR;
			entry_remove(idx);
		end
	endfunction

	function automatic logic [2:0] free_block(logic [31:0] addr);
		int idx;
		if (addr == 0)
			return ST_OK;
		idx = entry_find(addr);
		if (idx < 0)
			return ST_BAD_ADDR;
		if (blk_fr[idx])
			return ST_DOUBLE_FREE;
		merge_free(idx);
		return ST_OK;
	endfunction

	function automatic logic [2:0] resize_block(logic [31:0] addr, logic [31:0] sz,
			output logic [31:0] res);
		int idx;
		logic [31:0] cur, off, diff, moved;
		logic [2:0] st;
		res = '0;
		if (addr == 0)
			return claim_low(sz, res);
		idx = entry_find(addr);
		if (idx < 0 || blk_fr[idx])
			return ST_BAD_ADDR;
		cur = blk_pay[idx];
		off = blk_off[idx];
		if (sz == cur) begin
			res = addr;
			return ST_OK;
		end
		if (sz > cur) begin
			diff = sz - cur;
			if (idx + 1 < blk_n && blk_fr[idx+1] && blk_pay[idx+1] >= diff) begin
				blk_off[idx+1] = blk_off[idx+1] + diff;
				blk_pay[idx+1] = blk_pay[idx+1] - diff;
				blk_pay[idx]   = sz;
				res = addr;
				return ST_OK;
			end
			st = claim_low(sz, moved);
			if (st != ST_OK)
				return st;
			idx = entry_find(addr);
			if (idx >= 0)
				merge_free(idx);
			res = moved;
			return ST_OK;
		end
		if (idx + 1 < blk_n && blk_fr[idx+1]) begin
			blk_off[idx+1] = off + sz + HDR;
			blk_pay[idx+1] = blk_pay[idx+1] + cur - sz;
			blk_pay[idx]   = sz;
			res = addr;
			return ST_OK;
		end
		if (sz + HDR < cur) begin
			if (blk_n >= MAX_BLOCKS)
				return ST_TABLE_FULL;
			entry_insert(idx + 1, off + sz + HDR, cur - sz - HDR, 1'b1);
			blk_pay[idx] = sz;
			res = addr;
			return ST_OK;
		end
		return ST_NO_ROOM;
	endfunction

	function automatic answer_t serve_request(logic [2:0] op, logic [24:0] req,
			logic [31:0] addr);
		answer_t a;
		logic [31:0] sz, res, tf, ta, lf;
		logic [2:0] st;
		sz = ({7'd0, req} + 32'd15) & 32'hFFFF_FFF0;
		res = '0; st = ST_OK; tf = '0; ta = '0; lf = '0;
		case (op)
			OP_ALLOC_LOW: st = claim_low(sz, res);
			OP_ALLOC_HIGH: st = claim_high(sz, res);
			OP_FREE: st = free_block(addr);
			OP_RESIZE: begin
				if (addr != 0 && sz == 0)
					st = free_block(addr);
				else
					st = resize_block(addr, sz, res);
			end
			OP_REPORT: begin
				for (int i = 0; i < blk_n; i++) begin
					if (blk_fr[i]) begin
						tf += blk_pay[i];
						if (blk_pay[i] > lf)
							lf = blk_pay[i];
					end else begin
						ta += blk_pay[i];
					end
				end
			end
			default: ;
		endcase
		if (st != ST_OK && fails != FAIL_MAX &&
				(op == OP_ALLOC_LOW || op == OP_ALLOC_HIGH ||
				(op == OP_RESIZE && !(addr != 0 && sz == 0))))
			fails++;
		a.addr = (st != ST_OK) ? 32'd0 : res;
		a.st   = st;
		a.tf   = tf[24:0];
		a.ta   = ta[24:0];
		a.lf   = lf[24:0];
		a.fc   = fails;
		return a;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		logic [24:0] v;
		if (!arst_n) begin
			heap_base_q = '0;
			heap_len_q  = 32'd65536;
			fails       = '0;
			rebuild_heap();
			answers_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HEAP_BASE) begin
					heap_base_q = cfg_data;
				end else begin
					v = cfg_data[24:0];
					heap_len_q = (v > HEAP_LIMIT) ? {7'd0, HEAP_LIMIT} : {7'd0, v};
					rebuild_heap();
				end
			end
			if (done) begin
				if (answers_q.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					a = answers_q.pop_front();
					check_field("result_address", a.addr, result_address);
					check_field("status", a.st, status);
					check_field("total_free", a.tf, total_free);
					check_field("total_allocated", a.ta, total_allocated);
					check_field("largest_free", a.lf, largest_free);
					check_field("failure_count", a.fc, failure_count);
				end
			end
			if (start && !busy)
				answers_q.push_back(serve_request(operation, request_bytes, payload_address));
		end
	end

	initial errors = 0;

	final begin
		if (answers_q.size() != 0) begin
			$error("%0d responses never arrived", answers_q.size());
		end
	end
endmodule

// ===== tb/tb_first_fit_heap_allocator_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the first-fit heap allocator: clock, reset, request and register
// stimulus, watchdog and verdict. Depends on ffha_pkg, ffha_checker and the RTL.
module tb_first_fit_heap_allocator_top;
	import ffha_pkg::*;

	localparam int SETTLE = 700;
	localparam int IDLE_LIMIT = 6000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [24:0] request_bytes;
	logic [31:0] payload_address;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [31:0] result_address;
	logic [2:0]  status;
	logic [24:0] total_free;
	logic [24:0] total_allocated;
	logic [24:0] largest_free;
	logic [15:0] failure_count;
	int          errors;
	int          sent_cnt;
	int          answered_cnt;
	int          idle_cycles;
	logic [31:0] last_addr;
	logic [31:0] live_q[$];

	first_fit_heap_allocator_top dut (.*);
	ffha_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (start && !busy)
			sent_cnt <= sent_cnt + 1;
		if (done) begin
			answered_cnt <= answered_cnt + 1;
			if (status == ST_OK && result_address != 0 && !(result_address inside {live_q})) begin
				live_q.push_back(result_address);
				if (live_q.size() > 64)
					void'(live_q.pop_front());
			end
		end
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic issue(logic [2:0] op, logic [24:0] req, logic [31:0] addr);
		start           <= 1'b1;
		operation       <= op;
		request_bytes   <= req;
		payload_address <= addr;
		do @(posedge clk); while (busy);
	endtask

	task automatic issue_wait(logic [2:0] op, logic [24:0] req, logic [31:0] addr);
		issue(op, req, addr);
		start <= 1'b0;
		do @(posedge clk); while (!done);
		last_addr = result_address;
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		while (sent_cnt != answered_cnt)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [24:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 25'($urandom_range(0, 320));
		if (r < 95)
			return 25'($urandom_range(0, 8192));
		return 25'($urandom_range(0, 25'h1FF_FFFF));
	endfunction

	function automatic logic [31:0] pick_live(bit take);
		int k;
		logic [31:0] a;
		if (live_q.size() == 0 || $urandom_range(0, 9) == 0)
			return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		k = $urandom_range(0, live_q.size() - 1);
		a = live_q[k];
		if (take)
			live_q.delete(k);
		return a;
	endfunction

	task automatic random_burst(int n);
		int r;
		int gap;
		bit drain;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 28)
				issue(OP_ALLOC_LOW, pick_size(), $urandom);
			else if (r < 45)
				issue(OP_ALLOC_HIGH, pick_size(), $urandom);
			else if (r < 66)
				issue(OP_FREE, 25'($urandom), pick_live(1'b1));
			else if (r < 86)
				issue(OP_RESIZE, pick_size(), pick_live(1'b0));
			else if (r < 95)
				issue(OP_REPORT, 25'($urandom), $urandom);
			else
				issue(3'($urandom_range(5, 7)), 25'($urandom), $urandom);
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(10, 60);
			drain = ($urandom_range(0, 2) != 0);
			if (gap != 0 || drain) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
				if (drain) begin
					@(posedge clk);
					while (sent_cnt != answered_cnt)
						@(posedge clk);
				end
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		logic [31:0] a, b;
		arst_n          = 1'b0;
		start           = 1'b0;
		operation       = '0;
		request_bytes   = '0;
		payload_address = '0;
		cfg_valid       = 1'b0;
		cfg_index       = 1'b0;
		cfg_data        = '0;
		sent_cnt        = 0;
		answered_cnt    = 0;
		idle_cycles     = 0;
		last_addr       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_wait(OP_REPORT, '0, '0);
		issue_wait(OP_ALLOC_LOW, '0, '0);
		issue_wait(OP_ALLOC_LOW, 25'd1, '0);
		a = last_addr;
		issue_wait(OP_ALLOC_HIGH, 25'd100, 32'hFFFF_FFFF);
		issue_wait(OP_ALLOC_LOW, 25'h1FF_FFFF, '0);
		issue_wait(OP_ALLOC_HIGH, 25'h1FF_FFFF, '0);
		issue_wait(OP_FREE, '0, '0);
		issue_wait(OP_FREE, '0, 32'h0001_2345);
		issue_wait(OP_RESIZE, 25'd32, 32'hFFFF_FFFF);
		issue_wait(OP_RESIZE, 25'd16, a);
		issue_wait(OP_RESIZE, 25'd200, a);
		issue_wait(OP_RESIZE, 25'd64, a);
		issue_wait(OP_RESIZE, 25'd40000, a);
		a = last_addr;
		issue_wait(OP_RESIZE, 25'd0, a);
		issue_wait(OP_FREE, '0, a);
		issue_wait(OP_RESIZE, 25'd32, a);
		issue_wait(OP_RESIZE, 25'd32, '0);
		issue_wait(OP_ALLOC_HIGH, 25'd64, '0);
		b = last_addr;
		issue_wait(OP_RESIZE, 25'd40, b);
		issue_wait(OP_RESIZE, 25'd1, b);
		issue_wait(3'd5, 25'h1FF_FFFF, 32'hFFFF_FFFF);
		issue_wait(3'd6, '0, '0);
		issue_wait(3'd7, '0, '0);
		issue_wait(OP_REPORT, 25'h1FF_FFFF, 32'hFFFF_FFFF);

		random_burst(140);
		write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
		write_reg(REG_HEAP_BYTES, 32'd4096);
		live_q.delete();
		random_burst(110);
		write_reg(REG_HEAP_BYTES, 32'd0);
		random_burst(15);
		write_reg(REG_HEAP_BYTES, 32'd64);
		random_burst(15);
		write_reg(REG_HEAP_BASE, 32'h1234_5677);
		write_reg(REG_HEAP_BYTES, 32'hFFFF_FFFF);
		live_q.delete();
		random_burst(80);
		write_reg(REG_HEAP_BASE, 32'd0);
		write_reg(REG_HEAP_BYTES, 32'd2000);
		live_q.delete();
		random_burst(70);

		while (sent_cnt != answered_cnt)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && sent_cnt == answered_cnt)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/first_fit_heap_allocator_top.sv
tb/ffha_checker.sv
tb/tb_first_fit_heap_allocator_top.sv
